@@ rtl/core/rosc_pkg.sv @@
`default_nettype none
package rosc_pkg;

   localparam logic [2:0] MODE_DEFAULT     = 3'd0;
   localparam logic [2:0] MODE_STRETCH     = 3'd1;
   localparam logic [2:0] MODE_NOT_SMALLER = 3'd2;
   localparam logic [2:0] MODE_NOT_LARGER  = 3'd3;
   localparam logic [2:0] MODE_MIN_MAX     = 3'd4;
   localparam logic [2:0] MODE_SCALE_ONE   = 3'd5;

   localparam logic [2:0] REG_SCALING_MODE  = 3'd0;
   localparam logic [2:0] REG_TARGET_WIDTH  = 3'd1;
   localparam logic [2:0] REG_TARGET_HEIGHT = 3'd2;
   localparam logic [2:0] REG_MAX_WIDTH     = 3'd3;
   localparam logic [2:0] REG_MAX_HEIGHT    = 3'd4;
   localparam logic [2:0] REG_LIMIT_WIDTH   = 3'd5;
   localparam logic [2:0] REG_LIMIT_HEIGHT  = 3'd6;

   localparam int QUEUE_DEPTH = 4;

   // Each side carries multiplicand, multiplier, divisor and cap (four
   // dimensions plus two flags); the size division adds 2n+1 and n+1 bits.
   function automatic int desc_bits(input int n);
      return 11 * n + 6;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/rosc_queue.sv @@
`default_nettype none
module rosc_queue #(
   parameter int W     = 160,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         full,
   output logic         empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
      pop_data = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/rosc_div.sv @@
`default_nettype none
module rosc_div #(
   parameter int NW = 29,
   parameter int DW = 15,
   parameter int QB = 14,
   parameter int PW = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   input  logic [PW-1:0] pay_in,
   output logic          out_valid,
   output logic [QB-1:0] quo,
   output logic [PW-1:0] pay_out
);
   logic          v_ff   [QB+1];
   logic [NW-1:0] r_ff   [QB+1];
   logic [DW-1:0] d_ff   [QB+1];
   logic [QB-1:0] q_ff   [QB+1];
   logic          sat_ff [QB+1];
   logic [PW-1:0] p_ff   [QB+1];

   // A quotient that does not fit in QB bits saturates to all ones.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      r_ff[0]   <= num;
      d_ff[0]   <= den;
      q_ff[0]   <= '0;
      sat_ff[0] <= (num >= (NW'(den) << QB));
      p_ff[0]   <= pay_in;
   end

   for (genvar i = 0; i < QB; i++) begin : g_stage
      localparam int B = QB - 1 - i;
      logic [NW-1:0] dsh;
      logic          ge;

      assign dsh = NW'(d_ff[i]) << B;
      assign ge  = (r_ff[i] >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         r_ff[i+1]   <= ge ? (r_ff[i] - dsh) : r_ff[i];
         d_ff[i+1]   <= d_ff[i];
         q_ff[i+1]   <= q_ff[i] | (QB'(ge) << B);
         sat_ff[i+1] <= sat_ff[i];
         p_ff[i+1]   <= p_ff[i];
      end
   end

   assign out_valid = v_ff[QB];
   assign quo       = sat_ff[QB] ? '1 : q_ff[QB];
   assign pay_out   = p_ff[QB];

endmodule
`default_nettype wire

@@ rtl/core/rosc_front.sv @@
`default_nettype none
module rosc_front #(
   parameter int N = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [N-1:0]                        src_width,
   input  logic [N-1:0]                        src_height,
   input  logic [2:0]                          mode,
   input  logic [N-1:0]                        tw,
   input  logic [N-1:0]                        th,
   input  logic [N-1:0]                        mw,
   input  logic [N-1:0]                        mh,
   input  logic                                full,
   output logic                                push,
   output logic [rosc_pkg::desc_bits(N)-1:0]   push_data
);
   import rosc_pkg::*;

   typedef struct packed {
      logic [N-1:0] a;
      logic [N-1:0] b;
      logic [N-1:0] d;
      logic [N-1:0] cap;
      logic         rnd;
      logic         use_size;
   } side_type;

   typedef struct packed {
      logic [2*N:0] size_num;
      logic [N:0]   size_den;
      side_type     w;
      side_type     h;
   } desc_type;

   typedef enum logic [2:0] {
      CAND_ONE,
      CAND_TW,
      CAND_TH,
      CAND_MW,
      CAND_MH
   } cand_type;

   logic           adv, acc, v_ff, v_in;
   logic [N-1:0]   sw_c, sh_c, mn_c, mx_c;
   logic [N-1:0]   sw_ff, sh_ff, mx_ff;
   logic           wlt_ff;
   logic [2*N-1:0] p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff;
   cand_type       c_sel, c_w, c_h;
   logic [N-1:0]   num, den;
   desc_type       desc;

   always_comb begin
      sw_c = (src_width == '0) ? N'(1) : src_width;
      sh_c = (src_height == '0) ? N'(1) : src_height;
      mn_c = (sw_c < sh_c) ? sw_c : sh_c;
      mx_c = (sw_c < sh_c) ? sh_c : sw_c;
      adv  = !v_ff || !full;
      busy = !adv;
      acc  = start && adv;
      v_in = adv ? acc : v_ff;
      push = v_ff && !full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         sw_ff  <= sw_c;
         sh_ff  <= sh_c;
         mx_ff  <= mx_c;
         wlt_ff <= (sw_c < sh_c);
         p1_ff  <= (2*N)'(tw) * (2*N)'(sh_c);
         p2_ff  <= (2*N)'(th) * (2*N)'(sw_c);
         p3_ff  <= (2*N)'(mw) * (2*N)'(sh_c);
         p4_ff  <= (2*N)'(mh) * (2*N)'(sw_c);
         p5_ff  <= (2*N)'(mx_c) * (2*N)'(mw);
         p6_ff  <= (2*N)'(mh) * (2*N)'(mn_c);
      end
   end

   always_comb begin
      c_sel = CAND_ONE;
      if (mode == MODE_NOT_SMALLER) begin
         c_sel = (p1_ff < p2_ff) ? CAND_TH : CAND_TW;
      end else if (mode == MODE_NOT_LARGER) begin
         if (tw != '0 && th != '0) begin
            c_sel = (p2_ff < p1_ff) ? CAND_TH : CAND_TW;
         end else if (tw != '0) begin
            c_sel = CAND_TW;
         end else begin
            c_sel = CAND_TH;
         end
      end

      c_w = c_sel;
      if (mw != '0) begin
         case (c_sel)
            CAND_TW: if (mw < tw) c_w = CAND_MW;
            CAND_TH: if (p3_ff < p2_ff) c_w = CAND_MW;
            default: if (mw < sw_ff) c_w = CAND_MW;
         endcase
      end

      c_h = c_w;
      if (mh != '0) begin
         case (c_w)
            CAND_MW: if (p4_ff < p3_ff) c_h = CAND_MH;
            CAND_TW: if (p4_ff < p1_ff) c_h = CAND_MH;
            CAND_TH: if (mh < th) c_h = CAND_MH;
            default: if (mh < sh_ff) c_h = CAND_MH;
         endcase
      end

      unique case (c_h)
         CAND_TW: begin num = tw; den = sw_ff; end
         CAND_TH: begin num = th; den = sh_ff; end
         CAND_MW: begin num = mw; den = sw_ff; end
         CAND_MH: begin num = mh; den = sh_ff; end
         default: begin num = N'(1); den = N'(1); end
      endcase

      desc.size_num = (2*N+1)'({mw, 1'b1});
      desc.size_den = (N+1)'(2);
      desc.w = '{a: sw_ff, b: num, d: den, cap: '0, rnd: 1'b1, use_size: 1'b0};
      desc.h = '{a: sh_ff, b: num, d: den, cap: '0, rnd: 1'b1, use_size: 1'b0};

      unique case (mode)
         MODE_MIN_MAX: begin
            if (p5_ff > p6_ff) begin
               desc.size_num = (2*N+1)'({p6_ff, 1'b0}) + (2*N+1)'(mx_ff);
               desc.size_den = {mx_ff, 1'b0};
            end
            if (wlt_ff) begin
               desc.w = '{a: '0, b: N'(1), d: N'(1), cap: '0, rnd: 1'b0, use_size: 1'b1};
               desc.h = '{a: '0, b: sh_ff, d: sw_ff, cap: '0, rnd: 1'b0, use_size: 1'b1};
            end else begin
               desc.w = '{a: '0, b: sw_ff, d: sh_ff, cap: '0, rnd: 1'b0, use_size: 1'b1};
               desc.h = '{a: '0, b: N'(1), d: N'(1), cap: '0, rnd: 1'b0, use_size: 1'b1};
            end
         end
         MODE_DEFAULT: begin
            if (tw == '0 && th != '0) begin
               desc.w = '{a: sw_ff, b: th, d: sh_ff, cap: mw, rnd: 1'b1, use_size: 1'b0};
            end else begin
               desc.w = '{a: tw, b: N'(1), d: N'(1), cap: mw, rnd: 1'b1, use_size: 1'b0};
            end
            if (th == '0 && tw != '0) begin
               desc.h = '{a: sh_ff, b: tw, d: sw_ff, cap: mh, rnd: 1'b1, use_size: 1'b0};
            end else begin
               desc.h = '{a: th, b: N'(1), d: N'(1), cap: mh, rnd: 1'b1, use_size: 1'b0};
            end
         end
         MODE_STRETCH: begin
            desc.w = '{a: (tw == '0) ? sw_ff : tw, b: N'(1), d: N'(1), cap: mw,
                       rnd: 1'b1, use_size: 1'b0};
            desc.h = '{a: (th == '0) ? sh_ff : th, b: N'(1), d: N'(1), cap: mh,
                       rnd: 1'b1, use_size: 1'b0};
         end
         default: begin
         end
      endcase

      push_data = desc;
   end

endmodule
`default_nettype wire

@@ rtl/core/rosc_back.sv @@
`default_nettype none
module rosc_back #(
   parameter int N = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                empty,
   output logic                                pop,
   input  logic [rosc_pkg::desc_bits(N)-1:0]   pop_data,
   input  logic [N-1:0]                        limit_width,
   input  logic [N-1:0]                        limit_height,
   output logic                                rsp_strobe,
   output logic [N-1:0]                        rsp_dst_width,
   output logic [N-1:0]                        rsp_dst_height
);
   import rosc_pkg::*;

   typedef struct packed {
      logic [N-1:0] a;
      logic [N-1:0] b;
      logic [N-1:0] d;
      logic [N-1:0] cap;
      logic         rnd;
      logic         use_size;
   } side_type;

   typedef struct packed {
      logic [2*N:0] size_num;
      logic [N:0]   size_den;
      side_type     w;
      side_type     h;
   } desc_type;

   localparam int SB = $bits(side_type);

   logic           b0_v_ff;
   desc_type       b0_ff;
   logic           sz_v;
   logic [N-1:0]   sz_q;
   logic [2*SB-1:0] sz_pay;
   side_type       sz_w, sz_h;
   logic [N-1:0]   aw, ah;
   logic           m_v_ff;
   logic [2*N-1:0] pw_ff, ph_ff;
   side_type       mw_ff, mh_ff;
   logic [2*N:0]   nw, nh;
   logic           dw_v, dh_v;
   logic [N-1:0]   qw, qh, capw, caph;
   logic [N-1:0]   ow, oh;
   logic           strobe_ff;
   logic [N-1:0]   dst_w_ff, dst_h_ff;

   assign pop = !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_v_ff <= 1'b0;
      end else begin
         b0_v_ff <= !empty;
      end
      b0_ff <= pop_data;
   end

   rosc_div #(.NW(2*N+1), .DW(N+1), .QB(N), .PW(2*SB)) u_size_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (b0_v_ff),
      .num      (b0_ff.size_num),
      .den      (b0_ff.size_den),
      .pay_in   ({b0_ff.w, b0_ff.h}),
      .out_valid(sz_v),
      .quo      (sz_q),
      .pay_out  (sz_pay)
   );

   always_comb begin
      {sz_w, sz_h} = sz_pay;
      aw = sz_w.use_size ? sz_q : sz_w.a;
      ah = sz_h.use_size ? sz_q : sz_h.a;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else begin
         m_v_ff <= sz_v;
      end
      pw_ff <= (2*N)'(aw) * (2*N)'(sz_w.b);
      ph_ff <= (2*N)'(ah) * (2*N)'(sz_h.b);
      mw_ff <= sz_w;
      mh_ff <= sz_h;
   end

   // Rounding half away from zero is floor((2n + d) / 2d).
   always_comb begin
      nw = (2*N+1)'({pw_ff, 1'b0}) + (2*N+1)'({N{mw_ff.rnd}} & mw_ff.d);
      nh = (2*N+1)'({ph_ff, 1'b0}) + (2*N+1)'({N{mh_ff.rnd}} & mh_ff.d);
   end

   rosc_div #(.NW(2*N+1), .DW(N+1), .QB(N), .PW(N)) u_width_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (m_v_ff),
      .num      (nw),
      .den      ({mw_ff.d, 1'b0}),
      .pay_in   (mw_ff.cap),
      .out_valid(dw_v),
      .quo      (qw),
      .pay_out  (capw)
   );

   rosc_div #(.NW(2*N+1), .DW(N+1), .QB(N), .PW(N)) u_height_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (m_v_ff),
      .num      (nh),
      .den      ({mh_ff.d, 1'b0}),
      .pay_in   (mh_ff.cap),
      .out_valid(dh_v),
      .quo      (qh),
      .pay_out  (caph)
   );

   always_comb begin
      ow = qw;
      oh = qh;
      if (capw != '0 && capw < ow) begin
         ow = capw;
      end
      if (caph != '0 && caph < oh) begin
         oh = caph;
      end
      if (limit_width < ow) begin
         ow = limit_width;
      end
      if (limit_height < oh) begin
         oh = limit_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dw_v;
      end
      dst_w_ff <= ow;
      dst_h_ff <= oh;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_dst_width  = dst_w_ff;
   assign rsp_dst_height = dst_h_ff;

   a_width_in_limit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (dst_w_ff <= $past(limit_width)))
      else $error("Result width exceeds the width limit.");

   a_height_in_limit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (dst_h_ff <= $past(limit_height)))
      else $error("Result height exceeds the height limit.");

   a_sides_aligned: assert property (@(posedge clock) disable iff (reset)
      dw_v == dh_v)
      else $error("Width and height dividers are out of step.");

endmodule
`default_nettype wire

@@ rtl/core/resize_output_size_calc.sv @@
`default_nettype none
// Computes the output size of an aspect-preserving resize for one source size
// per transaction. A request is taken whenever start is high and busy is low;
// while busy stays low a new request may be issued every cycle, so the block
// sustains one size pair per clock. Each result appears on rsp_strobe and
// cannot be held off; results pass through two one-bit-per-stage divider
// pipelines in series (the min-max size, then the two output sides).
// Configuration writes are always accepted (csr_ready is high) and must
// only be made while no request is in flight.
module resize_output_size_calc #(
   parameter int DIM_BITS = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [DIM_BITS-1:0] req_src_width,
   input  logic [DIM_BITS-1:0] req_src_height,
   output logic                rsp_strobe,
   output logic [DIM_BITS-1:0] rsp_dst_width,
   output logic [DIM_BITS-1:0] rsp_dst_height,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [DIM_BITS-1:0] csr_data
);
   import rosc_pkg::*;

   localparam int DB = desc_bits(DIM_BITS);

   logic [2:0]          mode_ff;
   logic [DIM_BITS-1:0] tw_ff, th_ff, mw_ff, mh_ff, lw_ff, lh_ff;
   logic                full, empty, push, pop;
   logic [DB-1:0]       push_data, pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DEFAULT;
         tw_ff   <= '0;
         th_ff   <= '0;
         mw_ff   <= '0;
         mh_ff   <= '0;
         lw_ff   <= DIM_BITS'(16383);
         lh_ff   <= DIM_BITS'(16383);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SCALING_MODE:  mode_ff <= csr_data[2:0];
            REG_TARGET_WIDTH:  tw_ff   <= csr_data;
            REG_TARGET_HEIGHT: th_ff   <= csr_data;
            REG_MAX_WIDTH:     mw_ff   <= csr_data;
            REG_MAX_HEIGHT:    mh_ff   <= csr_data;
            REG_LIMIT_WIDTH:   lw_ff   <= csr_data;
            REG_LIMIT_HEIGHT:  lh_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   rosc_front #(.N(DIM_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .src_width (req_src_width),
      .src_height(req_src_height),
      .mode      (mode_ff),
      .tw        (tw_ff),
      .th        (th_ff),
      .mw        (mw_ff),
      .mh        (mh_ff),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   rosc_queue #(.W(DB), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .pop_data (pop_data),
      .full     (full),
      .empty    (empty)
   );

   rosc_back #(.N(DIM_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .empty         (empty),
      .pop           (pop),
      .pop_data      (pop_data),
      .limit_width   (lw_ff),
      .limit_height  (lh_ff),
      .rsp_strobe    (rsp_strobe),
      .rsp_dst_width (rsp_dst_width),
      .rsp_dst_height(rsp_dst_height)
   );

endmodule
`default_nettype wire

@@ bench/tb_resize_output_size_calc.sv @@
`timescale 1ns / 1ps
module tb_resize_output_size_calc;
   import rosc_pkg::*;

   localparam int DB = 14;
   localparam int LATENCY = 2 * DB + 6;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [DB-1:0] sw;
      logic [DB-1:0] sh;
   } size_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [DB-1:0] req_src_width = '0;
   logic [DB-1:0] req_src_height = '0;
   logic rsp_strobe;
   logic [DB-1:0] rsp_dst_width;
   logic [DB-1:0] rsp_dst_height;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [DB-1:0] csr_data = '0;

   resize_output_size_calc #(.DIM_BITS(DB)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_src_width(req_src_width), .req_src_height(req_src_height),
      .rsp_strobe(rsp_strobe), .rsp_dst_width(rsp_dst_width),
      .rsp_dst_height(rsp_dst_height), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   logic [2:0] m_mode;
   longint unsigned m_tw, m_th, m_mw, m_mh, m_lw, m_lh;

   size_pair_type pending_sizes[$];
   size_pair_type expected_sizes[$];
   int send_gap_pct = 0;
   int failures = 0;
   longint cycles = 0;

   typedef struct packed {
      logic [2:0] idx;
      logic [DB-1:0] val;
   } csr_write_type;
   csr_write_type csr_writes[$];

   function automatic longint unsigned round_div(longint unsigned n, longint unsigned d);
      return (2 * n + d) / (2 * d);
   endfunction

   function automatic bit ratio_lt(longint unsigned a, longint unsigned b,
                                   longint unsigned c, longint unsigned d);
      return a * d < c * b;
   endfunction

   function automatic size_pair_type predict_size(size_pair_type src);
      longint unsigned sw, sh, dw, dh, sz, mn, mx, num, den;
      size_pair_type r;
      sw = (src.sw == 0) ? 1 : src.sw;
      sh = (src.sh == 0) ? 1 : src.sh;
      dw = m_tw;
      dh = m_th;
      if (m_mode == MODE_MIN_MAX) begin
         sz = m_mw;
         mn = (sw < sh) ? sw : sh;
         mx = (sw > sh) ? sw : sh;
         if (mx * sz > m_mh * mn) sz = round_div(m_mh * mn, mx);
         if (sw < sh) begin
            dw = sz;
            dh = (sz * sh) / sw;
         end else begin
            dh = sz;
            dw = (sz * sw) / sh;
         end
      end else if (m_mode == MODE_STRETCH || m_mode == MODE_DEFAULT) begin
         if (m_mode == MODE_STRETCH) begin
            if (dw == 0) dw = sw;
            if (dh == 0) dh = sh;
         end else if (dw == 0 && dh != 0) begin
            dw = round_div(sw * dh, sh);
         end else if (dh == 0 && dw != 0) begin
            dh = round_div(sh * dw, sw);
         end
         if (m_mw != 0 && m_mw < dw) dw = m_mw;
         if (m_mh != 0 && m_mh < dh) dh = m_mh;
      end else begin
         num = 1;
         den = 1;
         if (m_mode == MODE_NOT_SMALLER) begin
            if (ratio_lt(m_tw, sw, m_th, sh)) begin
               num = m_th; den = sh;
            end else begin
               num = m_tw; den = sw;
            end
         end else if (m_mode == MODE_NOT_LARGER) begin
            if (m_tw > 0 && m_th > 0) begin
               if (ratio_lt(m_th, sh, m_tw, sw)) begin
                  num = m_th; den = sh;
               end else begin
                  num = m_tw; den = sw;
               end
            end else if (m_tw > 0) begin
               num = m_tw; den = sw;
            end else begin
               num = m_th; den = sh;
            end
         end
         if (m_mw != 0 && ratio_lt(m_mw, sw, num, den)) begin
            num = m_mw; den = sw;
         end
         if (m_mh != 0 && ratio_lt(m_mh, sh, num, den)) begin
            num = m_mh; den = sh;
         end
         dw = round_div(sw * num, den);
         dh = round_div(sh * num, den);
      end
      if (dw > m_lw) dw = m_lw;
      if (dh > m_lh) dh = m_lh;
      r.sw = dw[DB-1:0];
      r.sh = dh[DB-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_sizes.insert(expected_sizes.size(),
                                  predict_size({req_src_width, req_src_height}));
         end
         if ((!start || !busy) && pending_sizes.size() > 0 &&
             $urandom_range(99) >= send_gap_pct) begin
            start <= 1'b1;
            {req_src_width, req_src_height} <= pending_sizes.pop_front();
         end else if (!start || !busy) begin
            start <= 1'b0;
            req_src_width <= DB'($urandom);
            req_src_height <= DB'($urandom);
         end
      end
   end

   // Configuration driver; the model copy follows each accepted write.
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SCALING_MODE:  m_mode = csr_data[2:0];
               REG_TARGET_WIDTH:  m_tw = csr_data;
               REG_TARGET_HEIGHT: m_th = csr_data;
               REG_MAX_WIDTH:     m_mw = csr_data;
               REG_MAX_HEIGHT:    m_mh = csr_data;
               REG_LIMIT_WIDTH:   m_lw = csr_data;
               REG_LIMIT_HEIGHT:  m_lh = csr_data;
               default: ;
            endcase
         end
         if ((!csr_valid || csr_ready) && csr_writes.size() > 0) begin
            csr_valid <= 1'b1;
            {csr_index, csr_data} <= csr_writes.pop_front();
         end else if (!csr_valid || csr_ready) begin
            csr_valid <= 1'b0;
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      size_pair_type exp_size;
      if (!reset && rsp_strobe) begin
         if (expected_sizes.size() == 0) begin
            $display("%0t: unexpected transaction %0d x %0d", $time,
                     rsp_dst_width, rsp_dst_height);
            failures = failures + 1;
         end else begin
            exp_size = expected_sizes.pop_front();
            if (rsp_dst_width !== exp_size.sw) begin
               $display("%0t: dst_width expected %0d actual %0d", $time,
                        exp_size.sw, rsp_dst_width);
               failures = failures + 1;
            end
            if (rsp_dst_height !== exp_size.sh) begin
               $display("%0t: dst_height expected %0d actual %0d", $time,
                        exp_size.sh, rsp_dst_height);
               failures = failures + 1;
            end
         end
      end
   end

   function automatic logic [DB-1:0] rand_dim(bit allow_zero);
      int k;
      k = $urandom_range(9);
      if (k == 0) return allow_zero ? '0 : DB'(1);
      if (k == 1) return '1;
      if (k < 5) return DB'($urandom_range(64, 1));
      if (k < 7) return DB'($urandom_range(2000, 1));
      return DB'($urandom_range(16383, allow_zero ? 0 : 1));
   endfunction

   task automatic drain();
      while (pending_sizes.size() > 0 || start || expected_sizes.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic apply_config(logic [2:0] mode, logic [DB-1:0] tw, logic [DB-1:0] th,
                               logic [DB-1:0] mw, logic [DB-1:0] mh,
                               logic [DB-1:0] lw, logic [DB-1:0] lh);
      csr_writes.insert(csr_writes.size(), {REG_SCALING_MODE, DB'(mode)});
      csr_writes.insert(csr_writes.size(), {REG_TARGET_WIDTH, tw});
      csr_writes.insert(csr_writes.size(), {REG_TARGET_HEIGHT, th});
      csr_writes.insert(csr_writes.size(), {REG_MAX_WIDTH, mw});
      csr_writes.insert(csr_writes.size(), {REG_MAX_HEIGHT, mh});
      csr_writes.insert(csr_writes.size(), {REG_LIMIT_WIDTH, lw});
      csr_writes.insert(csr_writes.size(), {REG_LIMIT_HEIGHT, lh});
      if ($urandom_range(1)) begin
         csr_writes.insert(csr_writes.size(), {REG_UNMAPPED, DB'($urandom)});
      end
      while (csr_writes.size() > 0 || csr_valid) @(posedge clock);
   endtask

   task automatic push_size(logic [DB-1:0] w, logic [DB-1:0] h);
      size_pair_type s;
      s.sw = w;
      s.sh = h;
      pending_sizes.insert(pending_sizes.size(), s);
   endtask

   initial begin
      logic [2:0] mode;
      m_mode = MODE_DEFAULT;
      m_tw = 0; m_th = 0; m_mw = 0; m_mh = 0; m_lw = 16383; m_lh = 16383;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero sources and every mode under reset and chosen settings.
      push_size(1, 1);
      push_size('1, '1);
      push_size(0, 0);
      push_size('1, 1);
      push_size(1, '1);
      push_size(640, 480);
      drain();
      for (int m = 0; m < 8; m++) begin
         apply_config(3'(m), 300, 200, (m == 4) ? 100 : 0, (m == 4) ? 500 : 0, 16383, 16383);
         push_size(640, 480);
         push_size(0, 1000);
         push_size('1, 3);
         drain();
      end
      apply_config(MODE_STRETCH, 0, 0, 0, 0, 0, 0);
      push_size(100, 100);
      drain();
      apply_config(MODE_DEFAULT, 0, 0, 0, 0, 16383, 16383);
      push_size(100, 100);
      drain();
      apply_config(MODE_NOT_SMALLER, '1, '1, '1, '1, 16383, 16383);
      push_size(1, 1);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 21 : (phase == 1) ? 72 : 0;
         for (int blk = 0; blk < 10; blk++) begin
            mode = 3'($urandom_range(7));
            apply_config(mode, rand_dim(1), rand_dim(1), rand_dim(1), rand_dim(1),
                         ($urandom_range(9) == 0) ? DB'($urandom) : DB'(16383),
                         ($urandom_range(9) == 0) ? DB'($urandom) : DB'(16383));
            for (int i = 0; i < 24; i++) push_size(rand_dim(1), rand_dim(1));
            drain();
         end
      end

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
